[design/cgdt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Capped grid distance transform - shared definitions
// Default geometry, field widths, register map and item codes.
// ----------------------------------------------------------------------------
package cgdt_pkg;

   // default geometry
   localparam int DEF_MAX_SIDE      = 512;
   localparam int DEF_CAP_DISTANCE  = 10;
   localparam int DEF_FRACTION_BITS = 8;

   // fixed field widths
   localparam int DIST_W = 12;
   localparam int CFG_W  = 10;
   localparam int DATA_W = 32;
   localparam int ADDR_W = 3;

   localparam logic [CFG_W-1:0] CFG_SIDE_RESET = CFG_W'(200);

   // register map, word index taken from paddr[2]
   typedef enum logic {
      REG_GRID_WIDTH  = 1'b0,
      REG_GRID_HEIGHT = 1'b1
   } reg_index_type;

   // request codes
   typedef enum logic {
      FUNC_LOAD  = 1'b0,
      FUNC_FETCH = 1'b1
   } func_type;

endpackage
`default_nettype wire

[design/capped_grid_distance_transform_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Capped grid distance transform core
// Loads an occupancy grid in raster order and returns, per fetch, the capped
// Euclidean distance to the nearest occupied cell in unsigned fixed point.
// ----------------------------------------------------------------------------
// A load transfer writes one cell. A fetch transfer is accepted, then reads
// one window row at a time through the single read port of the row store
// (2*CAP_DISTANCE-1 rows), drains the pipeline and hands the result to the
// output register once that register is free. The block stalls its request
// side while a fetch is in work, so loads wait as well. The
// window rows pass one at a time through a shared search / square / compare
// unit that keeps the smallest squared distance; a constant root table turns
// it into the Q format result. The store holds MAX_SIDE x MAX_SIDE bits with
// no reset and no clearing pass: every cell must be loaded before it is
// fetched. A register write returns both raster positions to the origin;
// write registers only while the block is idle. Width or height of 0 acts
// as 1, values above MAX_SIDE act as MAX_SIDE.
// ----------------------------------------------------------------------------
module capped_grid_distance_transform_core #(
   parameter int MAX_SIDE      = cgdt_pkg::DEF_MAX_SIDE,
   parameter int CAP_DISTANCE  = cgdt_pkg::DEF_CAP_DISTANCE,
   parameter int FRACTION_BITS = cgdt_pkg::DEF_FRACTION_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic                          req_cell_occupied,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [cgdt_pkg::DIST_W-1:0]   rsp_distance,
   output logic                          rsp_last_cell,
   // register port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [cgdt_pkg::ADDR_W-1:0]   paddr,
   input  logic [cgdt_pkg::DATA_W-1:0]   pwdata,
   output logic [cgdt_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);

   import cgdt_pkg::*;

   localparam int SIDE_W     = $clog2(MAX_SIDE);
   localparam int SIDE_CNT_W = $clog2(MAX_SIDE + 1);
   localparam int CMP_W      = (CFG_W > SIDE_CNT_W) ? CFG_W : SIDE_CNT_W;
   localparam int POS_W      = SIDE_W + 2;
   localparam int REACH      = CAP_DISTANCE - 1;
   localparam int WIN        = 2 * CAP_DISTANCE - 1;
   localparam int STEP_W     = $clog2(WIN + 2);
   localparam int DX_W       = $clog2(CAP_DISTANCE + 1);
   localparam int LIMIT      = CAP_DISTANCE * CAP_DISTANCE;
   localparam int TBL_IDX_W  = $clog2(LIMIT + 1);
   localparam int D2_W       = $clog2(2 * LIMIT + 1);

   typedef logic [LIMIT:0][DIST_W-1:0] root_table_type;

   // round(sqrt(d2) * 2^FRACTION_BITS), masked to the result width
   function automatic root_table_type build_root_table();
      root_table_type tbl;
      longint         n;
      longint         rem;
      longint         res;
      longint         bits;
      for (int d = 0; d <= LIMIT; d++) begin
         n    = longint'(d) <<< (2 * FRACTION_BITS);
         rem  = n;
         res  = 0;
         bits = longint'(1) <<< 62;
         while (bits > rem) bits = bits >>> 2;
         while (bits != 0) begin
            if (rem >= res + bits) begin
               rem = rem - (res + bits);
               res = (res >>> 1) + bits;
            end else begin
               res = res >>> 1;
            end
            bits = bits >>> 2;
         end
         if (n > res * res + res) res = res + 1;
         tbl[d] = DIST_W'(res);
      end
      return tbl;
   endfunction

   localparam root_table_type ROOT_TABLE = build_root_table();

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // registers
   state_type            state_ff,      state_in;
   logic [CFG_W-1:0]     grid_width_ff, grid_width_in;
   logic [CFG_W-1:0]     grid_height_ff, grid_height_in;
   logic [SIDE_W-1:0]    load_x_ff,     load_x_in;
   logic [SIDE_W-1:0]    load_y_ff,     load_y_in;
   logic [SIDE_W-1:0]    fetch_x_ff,    fetch_x_in;
   logic [SIDE_W-1:0]    fetch_y_ff,    fetch_y_in;
   logic [SIDE_W-1:0]    cur_x_ff,      cur_x_in;
   logic [SIDE_W-1:0]    cur_y_ff,      cur_y_in;
   logic                 cur_last_ff,   cur_last_in;
   logic [STEP_W-1:0]    step_ff,       step_in;
   logic                 a_valid_ff,    a_valid_in;
   logic [STEP_W-1:0]    a_idx_ff,      a_idx_in;
   logic                 b_valid_ff,    b_valid_in;
   logic [STEP_W-1:0]    b_idx_ff,      b_idx_in;
   logic [TBL_IDX_W-1:0] best_ff,       best_in;
   logic                 rsp_valid_ff,  rsp_valid_in;
   logic [DIST_W-1:0]    rsp_dist_ff,   rsp_dist_in;
   logic                 rsp_last_ff,   rsp_last_in;

   // combinational
   logic [SIDE_CNT_W-1:0] width_eff;
   logic [SIDE_CNT_W-1:0] height_eff;
   logic                  cfg_write;
   logic                  req_take;
   logic                  load_take;
   logic                  fetch_take;
   logic                  load_x_end;
   logic                  load_y_end;
   logic                  fetch_x_end;
   logic                  fetch_y_end;
   logic                  rd_en;
   logic                  rd_ok;
   logic [POS_W-1:0]      row_pos;
   logic [SIDE_W-1:0]     rd_row;
   logic [WIN-1:0]        window;
   logic                  found;
   logic [DX_W-1:0]       min_dx;
   logic [DX_W-1:0]       dy_abs;
   logic [D2_W-1:0]       d2;
   logic                  better;
   logic                  out_free;

   // clamp a side register to 1..MAX_SIDE
   function automatic logic [SIDE_CNT_W-1:0] clamp_side(input logic [CFG_W-1:0] raw);
      logic [CMP_W-1:0] ext;
      ext = CMP_W'(raw);
      if (ext == '0) begin
         return SIDE_CNT_W'(1);
      end else if (ext > CMP_W'(MAX_SIDE)) begin
         return SIDE_CNT_W'(MAX_SIDE);
      end
      return SIDE_CNT_W'(ext);
   endfunction

   assign width_eff  = clamp_side(grid_width_ff);
   assign height_eff = clamp_side(grid_height_ff);

   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite & pready;

   always_comb begin
      prdata = '0;
      unique case (reg_index_type'(paddr[2]))
         REG_GRID_WIDTH:  prdata = DATA_W'(grid_width_ff);
         REG_GRID_HEIGHT: prdata = DATA_W'(grid_height_ff);
      endcase
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_take   = req_valid & ~req_stall;
   assign load_take  = req_take & (func_type'(req_func) == FUNC_LOAD);
   assign fetch_take = req_take & (func_type'(req_func) == FUNC_FETCH);

   // raster wrap points
   assign load_x_end  = (SIDE_CNT_W'(load_x_ff)  + SIDE_CNT_W'(1)) == width_eff;
   assign load_y_end  = (SIDE_CNT_W'(load_y_ff)  + SIDE_CNT_W'(1)) == height_eff;
   assign fetch_x_end = (SIDE_CNT_W'(fetch_x_ff) + SIDE_CNT_W'(1)) == width_eff;
   assign fetch_y_end = (SIDE_CNT_W'(fetch_y_ff) + SIDE_CNT_W'(1)) == height_eff;

   // window row cur_y + step - REACH, one per scan cycle
   assign rd_en   = (state_ff == ST_SCAN) && (step_ff < STEP_W'(WIN));
   assign row_pos = POS_W'(cur_y_ff) + POS_W'(step_ff);
   assign rd_ok   = (row_pos >= POS_W'(REACH)) &&
                    ((row_pos - POS_W'(REACH)) < POS_W'(height_eff));
   assign rd_row  = SIDE_W'(row_pos - POS_W'(REACH));

   cgdt_row_store #(
      .MAX_SIDE     (MAX_SIDE),
      .CAP_DISTANCE (CAP_DISTANCE)
   ) u_store (
      .clock      (clock),
      .wr_en      (load_take),
      .wr_row     (load_y_ff),
      .wr_col     (load_x_ff),
      .wr_bit     (req_cell_occupied),
      .rd_en      (rd_en),
      .rd_ok      (rd_ok),
      .rd_row     (rd_row),
      .centre_col (cur_x_ff),
      .side_w     (width_eff),
      .window     (window)
   );

   // shared unit: nearest set bit about the centre, then dx^2 + dy^2 vs best
   always_comb begin
      found  = 1'b0;
      min_dx = '0;
      for (int k = REACH; k >= 0; k--) begin
         if (window[REACH-k] | window[REACH+k]) begin
            found  = 1'b1;
            min_dx = DX_W'(k);
         end
      end
      if (b_idx_ff >= STEP_W'(REACH)) begin
         dy_abs = DX_W'(b_idx_ff - STEP_W'(REACH));
      end else begin
         dy_abs = DX_W'(STEP_W'(REACH) - b_idx_ff);
      end
      d2     = D2_W'(D2_W'(min_dx) * D2_W'(min_dx)) +
               D2_W'(D2_W'(dy_abs) * D2_W'(dy_abs));
      better = b_valid_ff & found & (d2 < D2_W'(best_ff));
   end

   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   // next state
   always_comb begin
      state_in       = state_ff;
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      load_x_in      = load_x_ff;
      load_y_in      = load_y_ff;
      fetch_x_in     = fetch_x_ff;
      fetch_y_in     = fetch_y_ff;
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      cur_last_in    = cur_last_ff;
      step_in        = step_ff;
      a_valid_in     = rd_en;
      a_idx_in       = step_ff;
      b_valid_in     = a_valid_ff;
      b_idx_in       = a_idx_ff;
      best_in        = better ? TBL_IDX_W'(d2) : best_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_dist_in    = rsp_dist_ff;
      rsp_last_in    = rsp_last_ff;

      if (load_take) begin
         if (load_x_end) begin
            load_x_in = '0;
            load_y_in = load_y_end ? '0 : load_y_ff + SIDE_W'(1);
         end else begin
            load_x_in = load_x_ff + SIDE_W'(1);
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (fetch_take) begin
               cur_x_in    = fetch_x_ff;
               cur_y_in    = fetch_y_ff;
               cur_last_in = fetch_x_end & fetch_y_end;
               step_in     = '0;
               best_in     = TBL_IDX_W'(LIMIT);
               state_in    = ST_SCAN;
               if (fetch_x_end) begin
                  fetch_x_in = '0;
                  fetch_y_in = fetch_y_end ? '0 : fetch_y_ff + SIDE_W'(1);
               end else begin
                  fetch_x_in = fetch_x_ff + SIDE_W'(1);
               end
            end
         end
         ST_SCAN: begin
            step_in = step_ff + STEP_W'(1);
            // last row leaves the compare stage on this cycle
            if (step_ff == STEP_W'(WIN + 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_dist_in  = ROOT_TABLE[best_ff];
               rsp_last_in  = cur_last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // register write rewinds both raster positions
      if (cfg_write) begin
         unique case (reg_index_type'(paddr[2]))
            REG_GRID_WIDTH:  grid_width_in  = pwdata[CFG_W-1:0];
            REG_GRID_HEIGHT: grid_height_in = pwdata[CFG_W-1:0];
         endcase
         load_x_in  = '0;
         load_y_in  = '0;
         fetch_x_in = '0;
         fetch_y_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         grid_width_ff  <= CFG_SIDE_RESET;
         grid_height_ff <= CFG_SIDE_RESET;
         load_x_ff      <= '0;
         load_y_ff      <= '0;
         fetch_x_ff     <= '0;
         fetch_y_ff     <= '0;
         step_ff        <= '0;
         a_valid_ff     <= 1'b0;
         b_valid_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         load_x_ff      <= load_x_in;
         load_y_ff      <= load_y_in;
         fetch_x_ff     <= fetch_x_in;
         fetch_y_ff     <= fetch_y_in;
         step_ff        <= step_in;
         a_valid_ff     <= a_valid_in;
         b_valid_ff     <= b_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      // payload, no reset needed
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      cur_last_ff <= cur_last_in;
      a_idx_ff    <= a_idx_in;
      b_idx_ff    <= b_idx_in;
      best_ff     <= best_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_distance  = rsp_dist_ff;
   assign rsp_last_cell = rsp_last_ff;

endmodule
`default_nettype wire

[design/cgdt_row_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Occupancy row store
// One row of the grid per word; single-bit writes, one registered row read
// per cycle, then the window around the centre column is cut out and masked.
// ----------------------------------------------------------------------------
module cgdt_row_store #(
   parameter int MAX_SIDE     = cgdt_pkg::DEF_MAX_SIDE,
   parameter int CAP_DISTANCE = cgdt_pkg::DEF_CAP_DISTANCE
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(MAX_SIDE)-1:0]       wr_row,
   input  logic [$clog2(MAX_SIDE)-1:0]       wr_col,
   input  logic                              wr_bit,
   input  logic                              rd_en,
   input  logic                              rd_ok,
   input  logic [$clog2(MAX_SIDE)-1:0]       rd_row,
   input  logic [$clog2(MAX_SIDE)-1:0]       centre_col,
   input  logic [$clog2(MAX_SIDE+1)-1:0]     side_w,
   output logic [2*CAP_DISTANCE-2:0]         window
);

   localparam int SIDE_W = $clog2(MAX_SIDE);
   localparam int REACH  = CAP_DISTANCE - 1;
   localparam int WIN    = 2 * CAP_DISTANCE - 1;
   localparam int POS_W  = SIDE_W + 2;

   logic [MAX_SIDE-1:0] row_mem [MAX_SIDE];
   logic [MAX_SIDE-1:0] row_ff;
   logic                row_ok_ff;
   logic [WIN-1:0]      window_ff;
   logic [WIN-1:0]      window_in;

   logic [POS_W-1:0]    col_pos [WIN];
   logic [SIDE_W-1:0]   col_idx [WIN];
   logic                col_ok  [WIN];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[wr_row][wr_col] <= wr_bit;
      end
      if (rd_en) begin
         row_ff <= row_mem[rd_row];
      end
      row_ok_ff <= rd_en & rd_ok;
      window_ff <= window_in;
   end

   // column centre_col + j - REACH, dropped when left of 0 or right of the grid
   always_comb begin
      for (int j = 0; j < WIN; j++) begin
         col_pos[j]   = POS_W'(centre_col) + POS_W'(j);
         col_ok[j]    = (col_pos[j] >= POS_W'(REACH)) &&
                        ((col_pos[j] - POS_W'(REACH)) < POS_W'(side_w));
         col_idx[j]   = SIDE_W'(col_pos[j] - POS_W'(REACH));
         window_in[j] = row_ok_ff & col_ok[j] & row_ff[col_idx[j]];
      end
   end

   assign window = window_ff;

endmodule
`default_nettype wire

[dv/capped_grid_distance_transform_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Capped grid distance transform core - testbench
// Loads occupancy grids of many shapes, fetches distances in raster order and
// checks each result against a bench copy of the grid. Both channels idle and
// stall at random, and register writes fall between phases while idle.
// ----------------------------------------------------------------------------
module capped_grid_distance_transform_core_tb;
   import cgdt_pkg::*;

   localparam int MAX_SIDE    = DEF_MAX_SIDE;
   localparam int CAP         = DEF_CAP_DISTANCE;
   localparam int FRAC        = DEF_FRACTION_BITS;
   localparam int REACH       = CAP - 1;          // window half-size per axis
   localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;

   // wait out a fetch in work, with some margin, before register writes
   localparam int SETTLE_CYCLES   = 2 * CAP + 3 + 10;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int IDLE_PCT        = 34;
   localparam int TOTAL_ITEMS     = 1100;
   localparam int HOLD_OFF_AT     = 160;          // lands in the 1 x 512 phase
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int CALM_FROM       = 700;          // no idling on either side
   localparam int CALM_TO         = 850;
   localparam int MAX_PRINTED     = 60;

   typedef struct packed {
      func_type func;
      logic     occupied;
   } grid_item_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              last_cell;
   } cell_result_type;

   // ---------------------------------------------------------------------
   // DUT connections, all inputs known from time zero
   // ---------------------------------------------------------------------
   logic              clock             = 1'b0;
   logic              reset             = 1'b1;
   logic              req_valid         = 1'b0;
   logic              req_stall;
   logic              req_func          = 1'b0;
   logic              req_cell_occupied = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall         = 1'b0;
   logic [DIST_W-1:0] rsp_distance;
   logic              rsp_last_cell;
   logic              psel              = 1'b0;
   logic              penable           = 1'b0;
   logic              pwrite            = 1'b0;
   logic [ADDR_W-1:0] paddr             = '0;
   logic [DATA_W-1:0] pwdata            = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   capped_grid_distance_transform_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_cell_occupied (req_cell_occupied),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_distance      (rsp_distance),
      .rsp_last_cell     (rsp_last_cell),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Bench state
   // ---------------------------------------------------------------------
   grid_item_type   pending_items[$];       // items waiting for the driver
   cell_result_type expected_distances[$];  // results owed by the block, oldest first

   bit grid_bits   [STORE_DEPTH];        // occupancy as the block should hold it
   bit loaded_bits [STORE_DEPTH];        // cells already queued for loading

   logic [CFG_W-1:0] width_reg  = CFG_SIDE_RESET;
   logic [CFG_W-1:0] height_reg = CFG_SIDE_RESET;

   // raster cursors: model ones move on accepted transfers, plan ones on queueing
   int model_load_pos  = 0;
   int model_fetch_pos = 0;
   int plan_load_pos   = 0;
   int plan_fetch_pos  = 0;

   int   items_queued = 0;
   int   items_taken  = 0;
   int   error_count  = 0;
   int   quiet_cycles = 0;
   int   hold_left    = 0;
   bit   hold_done    = 1'b0;
   logic calm;

   assign calm = items_taken >= CALM_FROM && items_taken < CALM_TO;

   // ---------------------------------------------------------------------
   // Grid model
   // ---------------------------------------------------------------------
   // 0 behaves as 1, anything over the store side behaves as the store side
   function automatic int clamp_side(logic [CFG_W-1:0] v);
      if (v == 0)
         return 1;
      if (v > MAX_SIDE)
         return MAX_SIDE;
      return int'(v);
   endfunction

   function automatic int next_raster(int pos, int total);
      return (pos + 1 >= total) ? 0 : pos + 1;
   endfunction

   function automatic int cell_addr(int pos, int w);
      return (pos / w) * MAX_SIDE + pos % w;
   endfunction

   // sqrt(d2) in Q.FRAC, rounded to nearest
   function automatic logic [DIST_W-1:0] fixed_root(int d2);
      longint n;
      longint q;
      longint t;
      n = longint'(d2) << (2 * FRAC);
      q = 0;
      for (int b = 15; b >= 0; b--) begin
         t = q | (longint'(1) << b);
         if (t * t <= n)
            q = t;
      end
      if (n > q * q + q)
         q++;
      return DIST_W'(q);
   endfunction

   // nearest occupied cell inside the clipped window, capped
   function automatic logic [DIST_W-1:0] predict_distance(int pos);
      int w;
      int h;
      int x;
      int y;
      int best;
      w    = clamp_side(width_reg);
      h    = clamp_side(height_reg);
      x    = pos % w;
      y    = pos / w;
      best = CAP * CAP;
      for (int dy = -REACH; dy <= REACH; dy++) begin
         for (int dx = -REACH; dx <= REACH; dx++) begin
            if (y + dy >= 0 && y + dy < h && x + dx >= 0 && x + dx < w &&
                grid_bits[(y + dy) * MAX_SIDE + x + dx] &&
                dx * dx + dy * dy < best) begin
               best = dx * dx + dy * dy;
            end
         end
      end
      if (best >= CAP * CAP)
         return DIST_W'(CAP << FRAC);
      return fixed_root(best);
   endfunction

   // advance the grid model by one accepted request transfer
   function automatic void step_grid_model(logic func, logic occupied);
      int w;
      int total;
      int pos;
      w     = clamp_side(width_reg);
      total = w * clamp_side(height_reg);
      if (func == FUNC_LOAD) begin
         pos = (model_load_pos < total) ? model_load_pos : 0;
         grid_bits[cell_addr(pos, w)] = occupied;
         model_load_pos = next_raster(pos, total);
      end else begin
         pos = (model_fetch_pos < total) ? model_fetch_pos : 0;
         expected_distances.push_back('{predict_distance(pos), pos == total - 1});
         model_fetch_pos = next_raster(pos, total);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   // a fetch is legal only once every cell its window can touch was loaded
   function automatic bit window_loaded(int pos);
      int w;
      int h;
      int x;
      int y;
      w = clamp_side(width_reg);
      h = clamp_side(height_reg);
      x = pos % w;
      y = pos / w;
      for (int dy = -REACH; dy <= REACH; dy++) begin
         for (int dx = -REACH; dx <= REACH; dx++) begin
            if (y + dy >= 0 && y + dy < h && x + dx >= 0 && x + dx < w &&
                !loaded_bits[(y + dy) * MAX_SIDE + x + dx]) begin
               return 1'b0;
            end
         end
      end
      return 1'b1;
   endfunction

   function automatic void queue_item(func_type func, logic occupied);
      int w;
      int total;
      w     = clamp_side(width_reg);
      total = w * clamp_side(height_reg);
      if (func == FUNC_LOAD) begin
         loaded_bits[cell_addr(plan_load_pos, w)] = 1'b1;
         plan_load_pos = next_raster(plan_load_pos, total);
      end else begin
         plan_fetch_pos = next_raster(plan_fetch_pos, total);
      end
      pending_items.push_back('{func, occupied});
      items_queued++;
   endfunction

   // loads run ahead of the fetch cursor; the occupancy bit on fetches is noise
   task automatic queue_random_items(int count, int fetch_pct, int density);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < fetch_pct && window_loaded(plan_fetch_pos))
            queue_item(FUNC_FETCH, 1'($urandom));
         else
            queue_item(FUNC_LOAD, $urandom_range(99) < density);
      end
   endtask

   task automatic report_mismatch(string what);
      if (error_count < MAX_PRINTED)
         $display("mismatch at %0t ns: %s", $time, what);
      error_count++;
   endtask

   // everything sent, everything back, and the last load given time to land
   task automatic wait_until_idle();
      do
         @(negedge clock);
      while (items_taken != items_queued || expected_distances.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // setup then access phase; the register takes the value at the end of the access phase
   task automatic write_reg(reg_index_type idx, logic [CFG_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'(idx) << 2;
      pwdata  <= DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == REG_GRID_WIDTH)
         width_reg = value;
      else
         height_reg = value;
      // any register write sends both raster positions back to the origin
      model_load_pos  = 0;
      model_fetch_pos = 0;
      plan_load_pos   = 0;
      plan_fetch_pos  = 0;
   endtask

   task automatic set_grid(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
      wait_until_idle();
      write_reg(REG_GRID_WIDTH, w);
      write_reg(REG_GRID_HEIGHT, h);
   endtask

   // ---------------------------------------------------------------------
   // Request driver: one transfer per accepted edge, payload held while stalled
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_requests
      grid_item_type nxt;
      bit            idle;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            items_taken++;
            step_grid_model(req_func, req_cell_occupied);
         end
         if (!req_valid || !req_stall) begin
            idle = !calm && $urandom_range(99) < IDLE_PCT;
            if (pending_items.size() != 0 && !idle) begin
               nxt = pending_items.pop_front();
               req_valid         <= 1'b1;
               req_func          <= nxt.func;
               req_cell_occupied <= nxt.occupied;
            end else begin
               req_valid         <= 1'b0;
               req_func          <= 1'($urandom);
               req_cell_occupied <= 1'($urandom);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response stall: random, plus one long hold-off so the block backs up
   // into its request side while the driver keeps offering
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : pace_results
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && items_taken >= HOLD_OFF_AT && pending_items.size() > 30) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_OFF_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= !calm && $urandom_range(99) < IDLE_PCT;
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor: field by field against the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      cell_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_distances.size() == 0) begin
            report_mismatch($sformatf("result with nothing owed: distance %0d last %0b",
                                      rsp_distance, rsp_last_cell));
         end else begin
            want = expected_distances.pop_front();
            if (rsp_distance !== want.distance)
               report_mismatch($sformatf("distance %0d, want %0d",
                                         rsp_distance, want.distance));
            if (rsp_last_cell !== want.last_cell)
               report_mismatch($sformatf("last_cell %0b, want %0b",
                                         rsp_last_cell, want.last_cell));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: too long without a transfer on either channel
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int w;
      int h;
      int density;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // 3 x 2 grid, one occupied corner: distances 0, 1, 2, 1, root 2, root 5,
      // end-of-grid flag on the sixth fetch, then the fetch cursor wraps
      set_grid(CFG_W'(3), CFG_W'(2));
      queue_item(FUNC_LOAD, 1'b1);
      repeat (5) queue_item(FUNC_LOAD, 1'b0);
      repeat (7) queue_item(FUNC_FETCH, 1'($urandom));
      // part of a reload, then a register write restarts raster order
      queue_item(FUNC_LOAD, 1'b0);
      queue_item(FUNC_LOAD, 1'b1);

      // zero sizes act as a single cell: free gives the cap, occupied gives 0
      set_grid(CFG_W'(0), CFG_W'(0));
      queue_item(FUNC_LOAD, 1'b0);
      queue_item(FUNC_FETCH, 1'b1);
      queue_item(FUNC_LOAD, 1'b1);
      queue_item(FUNC_FETCH, 1'b0);
      queue_item(FUNC_FETCH, 1'b1);

      // oversize and full-size sides
      set_grid(CFG_W'(1023), CFG_W'(1));
      queue_random_items(120, 50, 8);
      set_grid(CFG_W'(1), CFG_W'(1023));
      queue_random_items(120, 50, 8);
      set_grid(CFG_W'(8), CFG_W'(512));
      queue_random_items(120, 40, 5);

      // mostly small grids of random shape and density
      while (items_queued < TOTAL_ITEMS) begin
         w = ($urandom_range(4) == 0) ? 1 : $urandom_range(1, 24);
         h = ($urandom_range(4) == 0) ? 1 : $urandom_range(1, 24);
         case ($urandom_range(4))
            0: density = 2;
            1: density = 10;
            2: density = 30;
            3: density = 60;
            default: density = 95;
         endcase
         set_grid(CFG_W'(w), CFG_W'(h));
         queue_random_items($urandom_range(40, 120), $urandom_range(30, 70), density);
      end

      wait_until_idle();
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

[filelist.f]
design/cgdt_pkg.sv
design/cgdt_row_store.sv
design/capped_grid_distance_transform_core.sv
dv/capped_grid_distance_transform_core_tb.sv
